// File: rtl/tms_pkg.sv
// Shared types, constants and state encodings for the tiled mean / std-dev block.
// Used by tms_math and tiled_mean_stddev; depends on nothing else.
package tms_pkg;

    // Frame geometry limits (the _DEF ones are defaults for the top-level parameters)
    localparam int MAX_SIDE_DEF         = 2048;
    localparam int MAX_TILES_ACROSS_DEF = 16;
    localparam int MAX_TILES_DOWN       = 64;

    // Configuration reset values
    localparam logic [11:0] WIDTH_RST   = 12'd640;
    localparam logic [11:0] HEIGHT_RST  = 12'd480;
    localparam logic [4:0]  TACROSS_RST = 5'd4;
    localparam logic [6:0]  TDOWN_RST   = 7'd4;

    // Accumulator widths (count, sum, sum of squares over a whole tile)
    localparam int CNT_W = 23;
    localparam int SUM_W = 30;
    localparam int SQ_W  = 38;
    // Product and root working width
    localparam int PROD_W = 62;
    // Divider width used by the statistics unit
    localparam int QDIV_W = 32;
    // Divider width used for tile geometry
    localparam int GDIV_W = 12;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_TACROSS = 2'd2,
        CFG_TDOWN   = 2'd3
    } cfg_index_t;

    // One tile accumulator as held in memory
    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } acc_t;

    // Statistics handed back by the math unit
    typedef struct packed {
        logic [7:0] mean;
        logic [6:0] sd;
    } stat_t;

    // Main sequencer
    typedef enum logic [2:0] {
        ST_ISTART,
        ST_IWAIT,
        ST_RUN,
        ST_DRAIN,
        ST_READ,
        ST_LOAD,
        ST_MATH,
        ST_OUT
    } state_t;

    // Statistics unit sequencer
    typedef enum logic [3:0] {
        M_IDLE,
        M_MULA,
        M_MULB,
        M_SQRT,
        M_DIVM_GO,
        M_DIVM,
        M_DIVS_GO,
        M_DIVS,
        M_DONE
    } math_state_t;

endpackage

// File: rtl/tms_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-before-write on a same-address collision. No dependencies.
module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tms_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; divisor is never zero at the call sites.
module tms_div #(
    parameter int W = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    // Trial subtraction of one step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/tms_math.sv
// Tile statistics unit: shift-add products, bitwise integer square root and
// two divides give floor mean and floor population std-dev. Uses tms_pkg, tms_div.
module tms_math (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tms_pkg::acc_t acc,
    output logic          done,
    output tms_pkg::stat_t stat
);

    localparam int PW = tms_pkg::PROD_W;
    localparam int DW = tms_pkg::QDIV_W;

    tms_pkg::math_state_t state_reg;
    tms_pkg::math_state_t state_next;

    logic [tms_pkg::CNT_W-1:0] cnt_reg;
    logic [tms_pkg::SUM_W-1:0] sum_reg;
    logic [PW-1:0]             mc_reg;
    logic [tms_pkg::SUM_W-1:0] mp_reg;
    logic [PW-1:0]             acc_reg;
    logic [PW-1:0]             a_reg;
    logic [PW-1:0]             x_reg;
    logic [PW-1:0]             r_reg;
    logic [PW-1:0]             bit_reg;
    logic [4:0]                step_reg;
    logic [7:0]                mean_reg;
    logic [6:0]                sd_reg;

    logic [PW-1:0] acc_sum;
    logic [PW-1:0] root_try;
    logic          mul_last;
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic [DW-1:0] div_r;

    // Shared datapath terms
    always_comb
    begin
        acc_sum  = acc_reg + (mp_reg[0] ? mc_reg : '0);
        root_try = r_reg + bit_reg;
        mul_last = (state_reg == tms_pkg::M_MULA) ? (step_reg == 5'(tms_pkg::CNT_W - 1))
                                                  : (step_reg == 5'(tms_pkg::SUM_W - 1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tms_pkg::M_IDLE:
            begin
                if (start)
                begin
                    state_next = (acc.cnt == '0) ? tms_pkg::M_DONE : tms_pkg::M_MULA;
                end
            end
            tms_pkg::M_MULA:    if (mul_last) state_next = tms_pkg::M_MULB;
            tms_pkg::M_MULB:    if (mul_last) state_next = tms_pkg::M_SQRT;
            tms_pkg::M_SQRT:    if (bit_reg[0]) state_next = tms_pkg::M_DIVM_GO;
            tms_pkg::M_DIVM_GO: state_next = tms_pkg::M_DIVM;
            tms_pkg::M_DIVM:    if (div_done) state_next = tms_pkg::M_DIVS_GO;
            tms_pkg::M_DIVS_GO: state_next = tms_pkg::M_DIVS;
            tms_pkg::M_DIVS:    if (div_done) state_next = tms_pkg::M_DONE;
            tms_pkg::M_DONE:    state_next = tms_pkg::M_IDLE;
            default:            state_next = tms_pkg::M_IDLE;
        endcase
    end

    // Outputs and divider control
    always_comb
    begin
        div_start    = (state_reg == tms_pkg::M_DIVM_GO) || (state_reg == tms_pkg::M_DIVS_GO);
        div_dividend = (state_reg == tms_pkg::M_DIVM_GO) ? DW'(sum_reg) : r_reg[DW-1:0];
        done         = (state_reg == tms_pkg::M_DONE);
        stat.mean    = mean_reg;
        stat.sd      = sd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tms_pkg::M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tms_pkg::M_IDLE:
            begin
                if (start)
                begin
                    cnt_reg  <= acc.cnt;
                    sum_reg  <= acc.sum;
                    mc_reg   <= PW'(acc.sq);
                    mp_reg   <= tms_pkg::SUM_W'(acc.cnt);
                    acc_reg  <= '0;
                    step_reg <= '0;
                    mean_reg <= '0;
                    sd_reg   <= '0;
                end
            end
            tms_pkg::M_MULA, tms_pkg::M_MULB:
            begin
                // One multiplier bit per cycle
                mc_reg   <= {mc_reg[PW-2:0], 1'b0};
                mp_reg   <= {1'b0, mp_reg[tms_pkg::SUM_W-1:1]};
                acc_reg  <= acc_sum;
                step_reg <= step_reg + 5'd1;
                if (mul_last && (state_reg == tms_pkg::M_MULA))
                begin
                    a_reg    <= acc_sum;
                    mc_reg   <= PW'(sum_reg);
                    mp_reg   <= sum_reg;
                    acc_reg  <= '0;
                    step_reg <= '0;
                end
                else if (mul_last)
                begin
                    x_reg   <= (a_reg > acc_sum) ? (a_reg - acc_sum) : '0;
                    r_reg   <= '0;
                    bit_reg <= PW'(1) << (PW - 2);
                end
            end
            tms_pkg::M_SQRT:
            begin
                // One root bit per cycle
                if (x_reg >= root_try)
                begin
                    x_reg <= x_reg - root_try;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            tms_pkg::M_DIVM:
            begin
                if (div_done) mean_reg <= div_q[7:0];
            end
            tms_pkg::M_DIVS:
            begin
                if (div_done) sd_reg <= div_q[6:0];
            end
            default:
            begin
            end
        endcase
    end

    tms_div #(
        .W(DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (DW'(cnt_reg)),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Remainder is not needed for these divides
    logic unused_rem;
    assign unused_rem = ^div_r;

endmodule

// File: rtl/tiled_mean_stddev.sv
// Tiled mean / std-dev over a raster pixel stream. Accepts one pixel per cycle
// inside a band; per-tile accumulators live in tms_ram (read-modify-write with forwarding).
// At a band end input stalls: a drain state, then for each tile column read, load, products,
// root, two divides, done and result, with the math skipped for an empty tile, plus output
// wait. After reset and after each config write, geometry setup runs four divides with
// input held off. Reset is async, active low.
module tiled_mean_stddev #(
    parameter int MAX_SIDE         = tms_pkg::MAX_SIDE_DEF,
    parameter int MAX_TILES_ACROSS = tms_pkg::MAX_TILES_ACROSS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] frame_start
    // Tile results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] tile_col, [9:4] tile_row, [17:10] mean_value,
                                   // [24:18] std_dev, [31:25] zero
    output logic        m_tlast,   // last_of_band
    output logic        m_tuser,   // [0] last_of_frame
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int TAW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
    localparam int PSW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int GW  = tms_pkg::GDIV_W;

    tms_pkg::state_t state_reg;
    tms_pkg::state_t state_next;

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [4:0]  tacross_reg;
    logic [6:0]  tdown_reg;
    logic [1:0]  phase_reg;

    logic [11:0]    sx_reg;
    logic [11:0]    sy_reg;
    logic [PSW-1:0] col_reg;
    logic [PSW-1:0] row_reg;
    logic [PSW-1:0] xoff_reg;
    logic [PSW-1:0] yoff_reg;
    logic [TAW-1:0] tc_reg;
    logic [5:0]     tr_reg;

    logic                      s1_valid_reg;
    logic [TAW-1:0]            s1_addr_reg;
    logic [7:0]                s1_px_reg;
    logic                      wr_valid_reg;
    logic [TAW-1:0]            wr_addr_reg;
    tms_pkg::acc_t             wr_data_reg;
    logic [MAX_TILES_ACROSS-1:0] valid_reg;

    logic [TAW-1:0] k_reg;
    logic [5:0]     band_tr_reg;
    logic           band_last_reg;
    logic [3:0]     out_col_reg;
    logic [5:0]     out_row_reg;
    logic [7:0]     out_mean_reg;
    logic [6:0]     out_sd_reg;
    logic           out_lband_reg;
    logic           out_lframe_reg;

    // Effective geometry
    logic [12:0]    w_eff;
    logic [12:0]    h_eff;
    logic [12:0]    ta_c;
    logic [12:0]    td_c;
    logic [12:0]    ta_eff;
    logic [12:0]    td_eff;
    logic [TAW-1:0] ta_last;
    logic [5:0]     td_last;

    always_comb
    begin
        w_eff  = (width_reg == '0) ? 13'd1 :
                 ({1'b0, width_reg} > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : {1'b0, width_reg};
        h_eff  = (height_reg == '0) ? 13'd1 :
                 ({1'b0, height_reg} > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : {1'b0, height_reg};
        ta_c   = (tacross_reg == '0) ? 13'd1 :
                 (13'(tacross_reg) > 13'(MAX_TILES_ACROSS)) ? 13'(MAX_TILES_ACROSS)
                                                            : 13'(tacross_reg);
        td_c   = (tdown_reg == '0) ? 13'd1 :
                 (13'(tdown_reg) > 13'(tms_pkg::MAX_TILES_DOWN)) ? 13'(tms_pkg::MAX_TILES_DOWN)
                                                                 : 13'(tdown_reg);
        ta_eff  = (ta_c > w_eff) ? w_eff : ta_c;
        td_eff  = (td_c > h_eff) ? h_eff : td_c;
        ta_last = TAW'(ta_eff - 13'd1);
        td_last = 6'(td_eff - 13'd1);
    end

    // Geometry divider operands by setup phase
    logic          gdiv_start;
    logic [GW-1:0] gdiv_dividend;
    logic [GW-1:0] gdiv_divisor;
    logic          gdiv_done;
    logic [GW-1:0] gdiv_q;
    logic [GW-1:0] gdiv_r;

    always_comb
    begin
        gdiv_start = (state_reg == tms_pkg::ST_ISTART);
        case (phase_reg)
            2'd0:
            begin
                gdiv_dividend = w_eff[GW-1:0];
                gdiv_divisor  = ta_eff[GW-1:0];
            end
            2'd1:
            begin
                gdiv_dividend = h_eff[GW-1:0];
                gdiv_divisor  = td_eff[GW-1:0];
            end
            2'd2:
            begin
                gdiv_dividend = GW'(col_reg);
                gdiv_divisor  = sx_reg;
            end
            default:
            begin
                gdiv_dividend = GW'(row_reg);
                gdiv_divisor  = sy_reg;
            end
        endcase
    end

    tms_div #(
        .W(GW)
    ) u_gdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (gdiv_start),
        .dividend  (gdiv_dividend),
        .divisor   (gdiv_divisor),
        .done      (gdiv_done),
        .quotient  (gdiv_q),
        .remainder (gdiv_r)
    );

    // Position tracking for the item at the input
    logic           s_acc;
    logic           cfg_wr;
    logic [PSW-1:0] c_cur;
    logic [PSW-1:0] r_cur;
    logic [PSW-1:0] xo_cur;
    logic [PSW-1:0] yo_cur;
    logic [TAW-1:0] tc_cur;
    logic [5:0]     tr_cur;
    logic [12:0]    c1;
    logic [12:0]    r1;
    logic [12:0]    xo1;
    logic [12:0]    yo1;
    logic           row_end;
    logic           last_tr;
    logic           row_cont;
    logic           band_end;

    always_comb
    begin
        s_acc    = s_tvalid && s_tready;
        cfg_wr   = cfg_valid && cfg_ready;
        c_cur    = s_tuser ? '0 : col_reg;
        r_cur    = s_tuser ? '0 : row_reg;
        xo_cur   = s_tuser ? '0 : xoff_reg;
        yo_cur   = s_tuser ? '0 : yoff_reg;
        tc_cur   = s_tuser ? '0 : tc_reg;
        tr_cur   = s_tuser ? '0 : tr_reg;
        c1       = 13'(c_cur) + 13'd1;
        r1       = 13'(r_cur) + 13'd1;
        xo1      = 13'(xo_cur) + 13'd1;
        yo1      = 13'(yo_cur) + 13'd1;
        row_end  = !(c1 < w_eff);
        last_tr  = (tr_cur >= td_last);
        row_cont = (last_tr || (yo1 < 13'(sy_reg))) && (r1 < h_eff);
        band_end = row_end && !row_cont;
    end

    // Accumulator update for the item in the second stage
    tms_pkg::acc_t ram_rdata;
    tms_pkg::acc_t s1_base;
    tms_pkg::acc_t s1_new;
    logic [15:0]   px_sq;
    logic [TAW-1:0] ram_raddr;
    logic          ram_we;

    always_comb
    begin
        if (wr_valid_reg && (wr_addr_reg == s1_addr_reg))
        begin
            s1_base = wr_data_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            s1_base = ram_rdata;
        end
        else
        begin
            s1_base = '0;
        end
        px_sq      = s1_px_reg * s1_px_reg;
        s1_new.cnt = s1_base.cnt + 1'b1;
        s1_new.sum = s1_base.sum + tms_pkg::SUM_W'(s1_px_reg);
        s1_new.sq  = s1_base.sq + tms_pkg::SQ_W'(px_sq);
        ram_we     = s1_valid_reg;
        ram_raddr  = (state_reg == tms_pkg::ST_RUN) ? tc_cur : k_reg;
    end

    tms_ram #(
        .WIDTH($bits(tms_pkg::acc_t)),
        .DEPTH(MAX_TILES_ACROSS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (s1_new),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Statistics unit
    logic           math_start;
    tms_pkg::acc_t  math_acc;
    logic           math_done;
    tms_pkg::stat_t math_stat;

    always_comb
    begin
        math_start = (state_reg == tms_pkg::ST_LOAD);
        math_acc   = valid_reg[k_reg] ? ram_rdata : '0;
    end

    tms_math u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .start (math_start),
        .acc   (math_acc),
        .done  (math_done),
        .stat  (math_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tms_pkg::ST_ISTART: state_next = tms_pkg::ST_IWAIT;
            tms_pkg::ST_IWAIT:
            begin
                if (gdiv_done)
                begin
                    state_next = (phase_reg == 2'd3) ? tms_pkg::ST_RUN : tms_pkg::ST_ISTART;
                end
            end
            tms_pkg::ST_RUN:   if (s_acc && band_end) state_next = tms_pkg::ST_DRAIN;
            tms_pkg::ST_DRAIN: state_next = tms_pkg::ST_READ;
            tms_pkg::ST_READ:  state_next = tms_pkg::ST_LOAD;
            tms_pkg::ST_LOAD:  state_next = tms_pkg::ST_MATH;
            tms_pkg::ST_MATH:  if (math_done) state_next = tms_pkg::ST_OUT;
            tms_pkg::ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = (k_reg == ta_last) ? tms_pkg::ST_RUN : tms_pkg::ST_READ;
                end
            end
            default: state_next = tms_pkg::ST_ISTART;
        endcase
        if (cfg_wr)
        begin
            state_next = tms_pkg::ST_ISTART;
        end
    end

    // Handshake outputs
    always_comb
    begin
        s_tready  = (state_reg == tms_pkg::ST_RUN);
        m_tvalid  = (state_reg == tms_pkg::ST_OUT);
        cfg_ready = 1'b1;
        m_tdata   = {7'd0, out_sd_reg, out_mean_reg, out_row_reg, out_col_reg};
        m_tlast   = out_lband_reg;
        m_tuser   = out_lframe_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tms_pkg::ST_ISTART;
            phase_reg    <= '0;
            width_reg    <= tms_pkg::WIDTH_RST;
            height_reg   <= tms_pkg::HEIGHT_RST;
            tacross_reg  <= tms_pkg::TACROSS_RST;
            tdown_reg    <= tms_pkg::TDOWN_RST;
            sx_reg       <= '0;
            sy_reg       <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            xoff_reg     <= '0;
            yoff_reg     <= '0;
            tc_reg       <= '0;
            tr_reg       <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            valid_reg    <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes restart geometry setup
            if (cfg_wr)
            begin
                phase_reg <= '0;
                case (cfg_index)
                    tms_pkg::CFG_WIDTH:   width_reg   <= cfg_data;
                    tms_pkg::CFG_HEIGHT:  height_reg  <= cfg_data;
                    tms_pkg::CFG_TACROSS: tacross_reg <= cfg_data[4:0];
                    tms_pkg::CFG_TDOWN:   tdown_reg   <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
            else if ((state_reg == tms_pkg::ST_IWAIT) && gdiv_done)
            begin
                phase_reg <= phase_reg + 2'd1;
                case (phase_reg)
                    2'd0: sx_reg <= gdiv_q;
                    2'd1: sy_reg <= gdiv_q;
                    2'd2:
                    begin
                        tc_reg   <= (gdiv_q > GW'(ta_last)) ? ta_last : TAW'(gdiv_q);
                        xoff_reg <= PSW'(gdiv_r);
                    end
                    default:
                    begin
                        tr_reg   <= (gdiv_q > GW'(td_last)) ? td_last : 6'(gdiv_q);
                        yoff_reg <= PSW'(gdiv_r);
                    end
                endcase
            end

            // Advance raster position
            if (s_acc)
            begin
                if (!row_end)
                begin
                    col_reg <= PSW'(c1);
                    tr_reg  <= tr_cur;
                    row_reg <= r_cur;
                    yoff_reg <= yo_cur;
                    if ((tc_cur < ta_last) && (xo1 == 13'(sx_reg)))
                    begin
                        tc_reg   <= tc_cur + 1'b1;
                        xoff_reg <= '0;
                    end
                    else
                    begin
                        tc_reg   <= tc_cur;
                        xoff_reg <= PSW'(xo1);
                    end
                end
                else
                begin
                    col_reg  <= '0;
                    tc_reg   <= '0;
                    xoff_reg <= '0;
                    if (row_cont)
                    begin
                        row_reg  <= PSW'(r1);
                        yoff_reg <= PSW'(yo1);
                        tr_reg   <= tr_cur;
                    end
                    else if (last_tr || !(r1 < h_eff))
                    begin
                        row_reg  <= '0;
                        yoff_reg <= '0;
                        tr_reg   <= '0;
                    end
                    else
                    begin
                        row_reg  <= PSW'(r1);
                        yoff_reg <= '0;
                        tr_reg   <= tr_cur + 6'd1;
                    end
                end
            end

            // Second stage and write forwarding
            s1_valid_reg <= s_acc;
            wr_valid_reg <= s1_valid_reg && !(s_acc && s_tuser);

            // Entry valid bits: frame start and band readout drop them all
            if ((s_acc && s_tuser) ||
                ((state_reg == tms_pkg::ST_OUT) && m_tready && (k_reg == ta_last)))
            begin
                valid_reg <= '0;
            end
            else if (s1_valid_reg)
            begin
                valid_reg[s1_addr_reg] <= 1'b1;
            end

            // Readout tile index
            if (state_reg == tms_pkg::ST_DRAIN)
            begin
                k_reg <= '0;
            end
            else if ((state_reg == tms_pkg::ST_OUT) && m_tready)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Payload registers
    logic [TAW+3:0] k_ext;
    assign k_ext = {4'd0, k_reg};

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_addr_reg <= tc_cur;
            s1_px_reg   <= s_tdata;
        end
        if (s1_valid_reg)
        begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= s1_new;
        end
        if (s_acc && band_end)
        begin
            band_tr_reg   <= tr_cur;
            band_last_reg <= last_tr;
        end
        if ((state_reg == tms_pkg::ST_MATH) && math_done)
        begin
            out_col_reg    <= k_ext[3:0];
            out_row_reg    <= band_tr_reg;
            out_mean_reg   <= math_stat.mean;
            out_sd_reg     <= math_stat.sd;
            out_lband_reg  <= (k_reg == ta_last);
            out_lframe_reg <= (k_reg == ta_last) && band_last_reg;
        end
    end

`ifndef SYNTHESIS
    // Input and output never open together
    assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // Checks that the second stage holds an item only during streaming or drain
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (state_reg == tms_pkg::ST_RUN || state_reg == tms_pkg::ST_DRAIN))
        else $error("accumulator write outside streaming");

    // Last result of a band returns to streaming with no entry valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast && !cfg_valid) |=>
            (state_reg == tms_pkg::ST_RUN && valid_reg == '0))
        else $error("band readout did not clear accumulators");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for tiled_mean_stddev: streams pixel frames under several
// geometries and checks every tile result against a built-in statistics predictor.
// Depends on rtl/tms_pkg.sv and rtl/tiled_mean_stddev.sv.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        logic [7:0] pixel;
        logic       frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic [3:0] tile_col;
        logic [5:0] tile_row;
        logic [7:0] mean_value;
        logic [6:0] std_dev;
        logic       last_of_band;
        logic       last_of_frame;
    } tile_stat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = tms_pkg::CFG_WIDTH;
    logic [11:0] cfg_data = '0;

    tiled_mean_stddev u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pixel_item_t pending_pixels[$];
    tile_stat_t  expected_stats[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          quiet_cycles = 0;

    // Predictor state: registers, raster position and band accumulators
    logic [11:0]     reg_width = tms_pkg::WIDTH_RST;
    logic [11:0]     reg_height = tms_pkg::HEIGHT_RST;
    logic [4:0]      reg_tiles_across = tms_pkg::TACROSS_RST;
    logic [6:0]      reg_tiles_down = tms_pkg::TDOWN_RST;
    int unsigned     col_pos = 0;
    int unsigned     row_pos = 0;
    longint unsigned band_count[16];
    longint unsigned band_sum[16];
    longint unsigned band_sq[16];

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic clear_band_stats();
        for (int k = 0; k < 16; k++)
        begin
            band_count[k] = 0;
            band_sum[k] = 0;
            band_sq[k] = 0;
        end
    endtask

    // Advance the raster position by one pixel and queue any tile statistics it completes
    task automatic predict_tile_stats(pixel_item_t it);
        int unsigned     w, h, ta, td, sx, sy, tc, tr, band_end;
        longint unsigned cnt, a, b;
        tile_stat_t      st;
        w  = clamp_to(reg_width, 2048);
        h  = clamp_to(reg_height, 2048);
        ta = clamp_to(reg_tiles_across, 16);
        td = clamp_to(reg_tiles_down, 64);
        if (ta > w)
            ta = w;
        if (td > h)
            td = h;
        sx = w / ta;
        sy = h / td;
        if (it.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
            clear_band_stats();
        end
        tc = col_pos / sx;
        if (tc > ta - 1)
            tc = ta - 1;
        tr = row_pos / sy;
        if (tr > td - 1)
            tr = td - 1;
        band_count[tc] += 1;
        band_sum[tc] += it.pixel;
        band_sq[tc] += it.pixel * it.pixel;
        if (col_pos + 1 < w)
        begin
            col_pos++;
            return;
        end
        col_pos = 0;
        band_end = (tr == td - 1) ? h : (tr + 1) * sy;
        if (row_pos + 1 < band_end && row_pos + 1 < h)
        begin
            row_pos++;
            return;
        end
        for (int k = 0; k < ta; k++)
        begin
            cnt = band_count[k];
            st.tile_col = k[3:0];
            st.tile_row = tr[5:0];
            st.mean_value = '0;
            st.std_dev = '0;
            if (cnt != 0)
            begin
                a = cnt * band_sq[k];
                b = band_sum[k] * band_sum[k];
                st.mean_value = 8'(band_sum[k] / cnt);
                st.std_dev = (a > b) ? 7'(floor_sqrt(a - b) / cnt) : 7'd0;
            end
            st.last_of_band = (k == ta - 1);
            st.last_of_frame = (k == ta - 1) && (tr == td - 1);
            expected_stats.insert(expected_stats.size(), st);
        end
        clear_band_stats();
        if (tr == td - 1 || row_pos + 1 >= h)
            row_pos = 0;
        else
            row_pos++;
    endtask

    // Random idling, with a quiet stretch that has none
    function automatic bit idle_now();
        if (cycle_count >= 4000 && cycle_count < 7000)
            return 1'b0;
        return $urandom_range(0, 99) < 11;
    endfunction

    // Pixel driver: predict on acceptance, then present the next item or idle
    always @(posedge clk)
    begin
        pixel_item_t nxt;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_tile_stats('{pixel: s_tdata, frame_start: s_tuser});
            if (!s_tvalid || s_tready)
            begin
                if (pending_pixels.size() != 0 && !idle_now())
                begin
                    nxt = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.pixel;
                    s_tuser <= nxt.frame_start;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        tile_stat_t want;
        tile_stat_t got;
        if (rst_n)
        begin
            m_tready <= !idle_now();
            if (m_tvalid && m_tready)
            begin
                got.tile_col = m_tdata[3:0];
                got.tile_row = m_tdata[9:4];
                got.mean_value = m_tdata[17:10];
                got.std_dev = m_tdata[24:18];
                got.last_of_band = m_tlast;
                got.last_of_frame = m_tuser;
                if (expected_stats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected tile result col=%0d row=%0d",
                                 got.tile_col, got.tile_row);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("tile mismatch exp: col=%0d row=%0d mean=%0d sd=%0d",
                                     want.tile_col, want.tile_row, want.mean_value,
                                     want.std_dev, " lb=%0d lf=%0d",
                                     want.last_of_band, want.last_of_frame);
                            $display("tile mismatch got: col=%0d row=%0d mean=%0d sd=%0d",
                                     got.tile_col, got.tile_row, got.mean_value,
                                     got.std_dev, " lb=%0d lf=%0d",
                                     got.last_of_band, got.last_of_frame);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no item moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Hold until the pixel queue is drained and all tile results are back
    task automatic wait_until_drained();
        while (pending_pixels.size() != 0 || s_tvalid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(tms_pkg::cfg_index_t idx, logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            tms_pkg::CFG_WIDTH:   reg_width = value;
            tms_pkg::CFG_HEIGHT:  reg_height = value;
            tms_pkg::CFG_TACROSS: reg_tiles_across = value[4:0];
            tms_pkg::CFG_TDOWN:   reg_tiles_down = value[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [11:0] ta, logic [11:0] td);
        wait_until_drained();
        write_reg(tms_pkg::CFG_WIDTH, w);
        write_reg(tms_pkg::CFG_HEIGHT, h);
        write_reg(tms_pkg::CFG_TACROSS, ta);
        write_reg(tms_pkg::CFG_TDOWN, td);
    endtask

    task automatic queue_pixel(int p, bit fs);
        pending_pixels.insert(pending_pixels.size(), '{pixel: p[7:0], frame_start: fs});
    endtask

    // Stimulus
    initial
    begin
        int sent;
        int n;
        clear_band_stats();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small frame, two tiles across: extreme pixel values, restart mid-frame
        set_geometry(12'd4, 12'd2, 12'd2, 12'd1);
        queue_pixel(255, 1);
        queue_pixel(255, 0);
        queue_pixel(0, 0);
        queue_pixel(0, 0);
        queue_pixel(255, 0);
        queue_pixel(0, 0);
        queue_pixel(255, 0);
        queue_pixel(0, 0);
        queue_pixel(7, 0);
        queue_pixel(200, 1);
        for (int i = 0; i < 7; i++)
            queue_pixel(i * 37, 0);

        // Zero sides and zero tile counts act as one: every pixel is a frame
        set_geometry(12'd0, 12'd0, 12'd0, 12'd0);
        queue_pixel(0, 0);
        queue_pixel(255, 1);
        queue_pixel(128, 0);

        // Oversized sides and counts saturate; leave the row unfinished
        set_geometry(12'hFFF, 12'hFFF, 12'd31, 12'd127);
        for (int i = 0; i < 5; i++)
            queue_pixel($urandom_range(0, 255), i == 0);

        // Shrink the width with the row unfinished; the current column is still inside the new width
        set_geometry(12'd16, 12'd3, 12'd31, 12'd127);
        queue_pixel(99, 0);

        // Random geometries and frames, phases ending mid-band at random
        sent = 0;
        while (sent < 400)
        begin
            set_geometry(12'($urandom_range(1, 20)), 12'($urandom_range(1, 8)),
                         12'($urandom_range(0, 31)), 12'($urandom_range(0, 127)));
            n = $urandom_range(20, 80);
            for (int i = 0; i < n; i++)
                queue_pixel($urandom_range(0, 255),
                            (i == 0) ? ($urandom_range(0, 1) == 1)
                                     : ($urandom_range(0, 99) < 3));
            sent += n;
        end

        wait_until_drained();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
